// ===== sv/btda_pkg.sv =====
// shared types and constants for the binary to decimal ascii unit
package btda_pkg;

  localparam int WORD_W             = 32;
  localparam int MAX_DIGITS_DEFAULT = 10;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CHAR_W             = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // item after classification: sign flag and magnitude to convert
  typedef struct packed {
    logic              negative;
    logic [WORD_W-1:0] magnitude;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } back_state_e;

endpackage

// ===== sv/btda_front.sv =====
// front end: accepts an item, resolves its sign and magnitude, pushes it into the queue
module btda_front (
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [btda_pkg::WORD_W-1:0]     value_i,
  input  logic                            is_signed_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output btda_pkg::entry_t                push_entry_o
);
  import btda_pkg::*;

  logic negative;

  assign negative   = is_signed_i & value_i[WORD_W-1];
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  // magnitude is taken modulo 2^32, so the most negative value comes out right
  always_comb begin
    push_entry_o.negative  = negative;
    push_entry_o.magnitude = negative ? (~value_i + WORD_W'(1)) : value_i;
  end

endmodule

// ===== sv/btda_queue.sv =====
// short queue of classified items between front and back
module btda_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  btda_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output btda_pkg::entry_t  pop_entry_o,
  output logic              empty_o,
  output logic              full_o
);
  import btda_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign empty_o     = (count_q == '0);
  assign full_o      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign pop_entry_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/btda_back.sv =====
// back end: shift-and-add-3 conversion, leading zero skip and character output
module btda_back #(
  parameter int MAX_DIGITS = btda_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          queue_empty_i,
  input  btda_pkg::entry_t              pop_entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [btda_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_char_o
);
  import btda_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(WORD_W);
  localparam int REM_W = $clog2(MAX_DIGITS + 1);

  back_state_e        state_q, state_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [WORD_W-1:0]  bin_q, bin_d;
  logic [CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               ovf_q, ovf_d;
  logic               neg_q, neg_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         top_digit;
  logic               out_free;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                    : bcd_q[4*d +: 4];
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign out_free  = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    bcd_d       = bcd_q;
    bin_d       = bin_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    ovf_d       = ovf_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q & out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          pop_o     = 1'b1;
          bcd_d     = '0;
          bin_d     = pop_entry_i.magnitude;
          neg_d     = pop_entry_i.negative;
          ovf_d     = 1'b0;
          bit_cnt_d = '0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        // a bit leaving the top digit means the number is wider than the buffer
        bcd_d     = {bcd_adj[BCD_W-2:0], bin_q[WORD_W-1]};
        ovf_d     = ovf_q | bcd_adj[BCD_W-1];
        bin_d     = {bin_q[WORD_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + CNT_W'(1);
        rem_d     = REM_W'(MAX_DIGITS);
        if (bit_cnt_q == CNT_W'(WORD_W - 1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!ovf_q && top_digit == 4'd0 && rem_q != REM_W'(1)) begin
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          rem_d = rem_q - REM_W'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ZERO + {4'd0, top_digit};
          last_d      = (rem_q == REM_W'(1));
          bcd_d       = {bcd_q[BCD_W-5:0], 4'd0};
          rem_d       = rem_q - REM_W'(1);
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q     <= bcd_d;
    bin_q     <= bin_d;
    bit_cnt_q <= bit_cnt_d;
    rem_q     <= rem_d;
    ovf_q     <= ovf_d;
    neg_q     <= neg_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

`ifndef SYNTHESIS
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q == CHAR_MINUS) ||
                    (char_q >= CHAR_ZERO && char_q <= CHAR_ZERO + 8'd9))
    else $error("character outside digits and minus");
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && char_q == CHAR_MINUS) |-> !last_q)
    else $error("minus sign marked as last character");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("queue read while busy");
  a_emit_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_SIGN || state_q == ST_SKIP) |->
      rem_q != '0)
    else $error("no digits left while emitting");
`endif

endmodule

// ===== sv/binary_to_decimal_ascii_unit.sv =====
// top level of the binary to decimal ascii unit
// Converts a 32-bit word, signed or unsigned, into its decimal text, one ASCII
// character per output item, most significant first, with a leading '-' for
// negative signed values and last_char_o set on the final character. Items
// enter a two-entry queue; the back end then picks the item up, runs the
// one-bit-per-cycle shift-and-add-3 conversion, drops leading zeros at one per
// cycle, then emits one character per cycle (sign plus digits) while the output
// is not stalled. Dropped zeros and printed digits always add up to MAX_DIGITS.
// With MAX_DIGITS below the number's digit count only the low MAX_DIGITS digits
// are printed.
module binary_to_decimal_ascii_unit #(
  parameter int MAX_DIGITS = btda_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [btda_pkg::WORD_W-1:0]   value_i,
  input  logic                          is_signed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [btda_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_char_o
);
  import btda_pkg::*;

  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   pop;
  logic   queue_empty;
  logic   queue_full;

  btda_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .is_signed_i  (is_signed_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  btda_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .empty_o      (queue_empty),
    .full_o       (queue_full)
  );

  btda_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .pop_entry_i   (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o)
  );

endmodule
